FILE: design/breakpoint_envelope_interpolator_macros.svh
// Assertion macros for the breakpoint envelope interpolator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef BREAKPOINT_ENVELOPE_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_ENVELOPE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BEI_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BEI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bei_pkg.sv
// Shared types and constants of the breakpoint envelope interpolator.
// No dependencies; imported by bei_if, bei_muldiv, the top level and the testbench.
package bei_pkg;

  // Field widths.
  localparam int POS_W = 16;
  localparam int LVL_W = 16;
  localparam int STATUS_W = 2;

  // Breakpoint table size and derived widths.
  localparam int MAX_POINTS = 16;
  localparam int PT_AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  // Position 1.0 in unsigned Q1.15.
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(32768);

  // Opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_VALUE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = LVL_W;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END = 1'd1;

  typedef struct packed {
    logic opcode;
    logic [POS_W-1:0] position;
    logic signed [LVL_W-1:0] level;
  } bei_req_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] value;
    logic [STATUS_W-1:0] status;
  } bei_rsp_t;

  // One stored breakpoint.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic signed [LVL_W-1:0] lvl;
  } bei_point_t;

  // Command to the serial multiply-divide unit.
  typedef struct packed {
    logic start;
    logic [LVL_W-1:0] mag;
    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] den;
  } bei_md_cmd_t;

  // Status of the serial multiply-divide unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic [LVL_W-1:0] quo;
  } bei_md_rsp_t;

endpackage

FILE: design/bei_if.sv
// Valid/ready stream interfaces for requests and results.
// Depends on bei_pkg for the payload types.
interface bei_req_if import bei_pkg::*; ();
  logic valid;
  logic ready;
  bei_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bei_rsp_if import bei_pkg::*; ();
  logic valid;
  logic ready;
  bei_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/bei_point_ram.sv
// Generic simple dual-port RAM with a registered read port.
// No package dependency; holds the breakpoint table.
module bei_point_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic re,
  input  logic [AW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bei_muldiv.sv
// Bit-serial unsigned multiply followed by restoring divide.
// Depends on bei_pkg; computes (mag * dx) / den, one bit per cycle.
module bei_muldiv import bei_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  bei_md_cmd_t cmd,
  output bei_md_rsp_t rsp
);

  localparam int PROD_W = LVL_W + POS_W;
  localparam int MAX_STEPS = (POS_W > LVL_W) ? POS_W : LVL_W;
  localparam int STEP_W = $clog2(MAX_STEPS);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL = 2'd1;
  localparam logic [1:0] M_DIV = 2'd2;

  logic [1:0] phase;
  logic [STEP_W-1:0] cnt;
  logic [PROD_W-1:0] prod;
  logic [LVL_W-1:0] mcand;
  logic [POS_W-1:0] den;
  logic done;

  logic [LVL_W:0] mul_sum;
  logic [POS_W:0] trial;
  logic [POS_W:0] trial_sub;
  logic ge;
  logic [POS_W-1:0] rem_next;

  // Multiply step: add the multiplicand into the high half when the low bit is set.
  always_comb begin
    mul_sum = {1'b0, prod[PROD_W-1:POS_W]};
    if (prod[0]) begin
      mul_sum = {1'b0, prod[PROD_W-1:POS_W]} + {1'b0, mcand};
    end
  end

  // Divide step: shift in the next dividend bit and try to subtract the divisor.
  // The high part stays below the divisor, since the quotient fits LVL_W bits.
  always_comb begin
    trial = {prod[PROD_W-1:LVL_W], prod[LVL_W-1]};
    trial_sub = trial - {1'b0, den};
    ge = (trial >= {1'b0, den});
    rem_next = ge ? trial_sub[POS_W-1:0] : trial[POS_W-1:0];
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        M_IDLE: begin
          if (cmd.start) begin
            prod <= {{LVL_W{1'b0}}, cmd.dx};
            mcand <= cmd.mag;
            den <= cmd.den;
            cnt <= STEP_W'(POS_W - 1);
            phase <= M_MUL;
          end
        end
        M_MUL: begin
          prod <= {mul_sum, prod[POS_W-1:1]};
          if (cnt == '0) begin
            cnt <= STEP_W'(LVL_W - 1);
            phase <= M_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        M_DIV: begin
          prod <= {rem_next, prod[LVL_W-2:0], ge};
          if (cnt == '0) begin
            done <= 1'b1;
            phase <= M_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: begin
          phase <= M_IDLE;
        end
      endcase
    end
  end

  assign rsp.busy = (phase != M_IDLE);
  assign rsp.done = done;
  assign rsp.quo = prod[LVL_W-1:0];

endmodule

FILE: design/breakpoint_envelope_interpolator.sv
// Top level of the breakpoint envelope interpolator: control sequencer and table.
// Depends on bei_pkg, bei_if, bei_point_ram, bei_muldiv and the assertion macros.
`include "breakpoint_envelope_interpolator_macros.svh"

// Piecewise linear envelope over a sorted table of up to MAX_POINTS breakpoints,
// framed by start_level at position 0 and end_level at position 1.0 (32768).
// One request is processed at a time; the table lives in a RAM with one
// registered read port, which is walked one entry at a time, a read then a
// compare. An evaluate request at position 0 or at or above 1.0 answers
// straight from the end levels. Any other evaluate walks the table up to the
// first stored point not below the query, then runs a bit-serial multiply
// and a bit-serial divide. An insert walks the table the same way, then moves
// each stored point above the slot up one slot, through the same RAM port.
// An insert into a full table is answered with ST_FULL and changes nothing.
// The next request is accepted while a result still waits in the output
// register. Configuration writes are taken at any time but are meant for
// idle periods.
module breakpoint_envelope_interpolator import bei_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bei_req_if.sink req,
  bei_rsp_if.source rsp
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_CMP = 4'd2;
  localparam logic [3:0] S_SH_RD = 4'd3;
  localparam logic [3:0] S_SH_WR = 4'd4;
  localparam logic [3:0] S_PUT = 4'd5;
  localparam logic [3:0] S_CALC = 4'd6;
  localparam logic [3:0] S_WAIT = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  logic [3:0] state;
  logic [CNT_W-1:0] count;
  logic signed [LVL_W-1:0] start_level;
  logic signed [LVL_W-1:0] end_level;

  // Request being worked on.
  logic op;
  logic [POS_W-1:0] x;
  logic signed [LVL_W-1:0] lv;

  // Search index, shift index and the two neighbors.
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] j;
  logic [POS_W-1:0] a_pos;
  logic signed [LVL_W-1:0] a_lvl;
  logic [POS_W-1:0] b_pos;
  logic signed [LVL_W-1:0] b_lvl;

  // Pending and delivered result.
  bei_rsp_t res;
  bei_rsp_t out_data;
  logic out_valid;

  // Table RAM signals.
  logic ram_we;
  logic [PT_AW-1:0] ram_waddr;
  bei_point_t ram_wdata;
  logic ram_re;
  logic [PT_AW-1:0] ram_raddr;
  bei_point_t ram_rdata;
  logic [CNT_W-1:0] j_m1;

  // Interpolation arithmetic.
  bei_md_cmd_t md_cmd;
  bei_md_rsp_t md_rsp;
  logic signed [LVL_W:0] diff;
  logic signed [LVL_W:0] diff_abs;
  logic neg;
  logic signed [LVL_W:0] q_ext;
  logic signed [LVL_W:0] q_s;
  logic signed [LVL_W:0] interp;
  logic [3:0] after_search;
  logic req_fire;

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  assign j_m1 = j - 1'b1;

  // RAM port control: reads while walking or moving, writes while moving or placing.
  always_comb begin
    ram_re = 1'b0;
    ram_raddr = k[PT_AW-1:0];
    ram_we = 1'b0;
    ram_waddr = k[PT_AW-1:0];
    ram_wdata = '{pos: x, lvl: lv};
    case (state)
      S_SCAN: begin
        ram_re = (k != count);
      end
      S_SH_RD: begin
        ram_re = 1'b1;
        ram_raddr = j_m1[PT_AW-1:0];
      end
      S_SH_WR: begin
        ram_we = 1'b1;
        ram_waddr = j[PT_AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_PUT: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bei_point_ram #(
    .WIDTH($bits(bei_point_t)),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Where the sequencer goes once the slot is found.
  always_comb begin
    if (op == OP_INSERT) begin
      after_search = (count > k) ? S_SH_RD : S_PUT;
    end else begin
      after_search = S_CALC;
    end
  end

  // Slope terms: magnitude of the level step, sign applied after the divide.
  always_comb begin
    diff = {b_lvl[LVL_W-1], b_lvl} - {a_lvl[LVL_W-1], a_lvl};
    neg = diff[LVL_W];
    diff_abs = neg ? -diff : diff;
    q_ext = {1'b0, md_rsp.quo};
    q_s = neg ? -q_ext : q_ext;
    interp = {a_lvl[LVL_W-1], a_lvl} + q_s;
  end

  assign md_cmd.start = (state == S_CALC) && (b_pos > a_pos);
  assign md_cmd.mag = diff_abs[LVL_W-1:0];
  assign md_cmd.dx = x - a_pos;
  assign md_cmd.den = b_pos - a_pos;

  bei_muldiv u_muldiv (
    .clk(clk),
    .rst(rst),
    .cmd(md_cmd),
    .rsp(md_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_level <= '0;
      end_level <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START: start_level <= cfg_data;
        CFG_END: end_level <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            op <= req.data.opcode;
            lv <= req.data.level;
            k <= '0;
            a_pos <= '0;
            a_lvl <= start_level;
            // Inserts above one are clamped to one.
            if (req.data.opcode == OP_INSERT && req.data.position > POS_ONE) begin
              x <= POS_ONE;
            end else begin
              x <= req.data.position;
            end
            if (req.data.opcode == OP_EVAL) begin
              if (req.data.position == '0) begin
                res <= '{value: start_level, status: ST_VALUE};
                state <= S_RESP;
              end else if (req.data.position >= POS_ONE) begin
                res <= '{value: end_level, status: ST_VALUE};
                state <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end else if (count == CNT_MAX) begin
              res <= '{value: '0, status: ST_FULL};
              state <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Past the last stored point: the right neighbor is the end point.
          if (k == count) begin
            b_pos <= POS_ONE;
            b_lvl <= end_level;
            j <= count;
            state <= after_search;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (ram_rdata.pos < x) begin
            a_pos <= ram_rdata.pos;
            a_lvl <= ram_rdata.lvl;
            k <= k + 1'b1;
            state <= S_SCAN;
          end else begin
            b_pos <= ram_rdata.pos;
            b_lvl <= ram_rdata.lvl;
            j <= count;
            state <= after_search;
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          j <= j_m1;
          state <= (j_m1 > k) ? S_SH_RD : S_PUT;
        end
        S_PUT: begin
          count <= count + 1'b1;
          res <= '{value: '0, status: ST_INSERTED};
          state <= S_RESP;
        end
        S_CALC: begin
          if (b_pos > a_pos) begin
            state <= S_WAIT;
          end else begin
            res <= '{value: a_lvl, status: ST_VALUE};
            state <= S_RESP;
          end
        end
        S_WAIT: begin
          if (md_rsp.done) begin
            res <= '{value: interp[LVL_W-1:0], status: ST_VALUE};
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded from the pending result once the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
      out_data <= res;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Checks on table bookkeeping and the arithmetic handoff.
  `BEI_ASSERT(a_count_bound, clk, rst, 1'b1, count <= CNT_MAX, "point count above table size")
  `BEI_ASSERT_NEXT(a_full_holds, clk, rst, req_fire && req.data.opcode == OP_INSERT && count == CNT_MAX, count == CNT_MAX, "insert into full table changed count")
  `BEI_ASSERT(a_md_start_idle, clk, rst, md_cmd.start, !md_rsp.busy, "divide unit started while busy")
  `BEI_ASSERT(a_wr_in_table, clk, rst, ram_we, CNT_W'(ram_waddr) <= count, "table write beyond stored points")

endmodule

FILE: tb/breakpoint_envelope_interpolator_tb.sv
// Self-checking testbench for the breakpoint envelope interpolator.
// Depends on bei_pkg, the bei_req_if/bei_rsp_if stream interfaces and the block itself.
// Directed table first, then random requests, mostly evaluates, over the filled table under several levels.
module breakpoint_envelope_interpolator_tb import bei_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [LVL_W-1:0] LVL_MIN = 16'sh8000;
  localparam logic signed [LVL_W-1:0] LVL_MAX = 16'sh7FFF;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_REQUESTS = 90;
  localparam int DRAIN_CYCLES = 80;

  typedef enum logic {ROW_ITEM, ROW_LEVELS} row_kind_t;

  // One directed step: a request, or a write of both end levels.
  typedef struct packed {
    row_kind_t kind;
    logic opcode;
    logic [POS_W-1:0] position;
    logic signed [LVL_W-1:0] level;
    logic signed [LVL_W-1:0] end_level;
    logic known;
    logic signed [LVL_W-1:0] value;
    logic [STATUS_W-1:0] status;
  } step_row_t;

  localparam step_row_t DIRECTED [26] = '{
    // Out of reset both ends sit at zero and the table is empty.
    '{ROW_ITEM, OP_EVAL, 16'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, ST_VALUE},
    '{ROW_ITEM, OP_EVAL, 16'd32768, 16'sd0, 16'sd0, 1'b1, 16'sd0, ST_VALUE},
    '{ROW_ITEM, OP_EVAL, 16'd16384, 16'sd0, 16'sd0, 1'b1, 16'sd0, ST_VALUE},
    // Extreme end levels.
    '{ROW_LEVELS, OP_EVAL, 16'd0, LVL_MIN, LVL_MAX, 1'b0, 16'sd0, ST_VALUE},
    '{ROW_ITEM, OP_EVAL, 16'd0, LVL_MAX, 16'sd0, 1'b1, LVL_MIN, ST_VALUE},
    '{ROW_ITEM, OP_EVAL, 16'd65535, LVL_MIN, 16'sd0, 1'b1, LVL_MAX, ST_VALUE},
    '{ROW_ITEM, OP_EVAL, 16'd1, 16'sd0, 16'sd0, 1'b0, 16'sd0, ST_VALUE},
    // Insert above one saturates, inserts at zero and at equal positions.
    '{ROW_ITEM, OP_INSERT, 16'd40000, 16'sd100, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd0, LVL_MAX, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd0, -16'sd5, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd16384, LVL_MAX, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd16384, LVL_MIN, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_EVAL, 16'd16384, 16'sd0, 16'sd0, 1'b0, 16'sd0, ST_VALUE},
    '{ROW_ITEM, OP_EVAL, 16'd32767, 16'sd0, 16'sd0, 1'b0, 16'sd0, ST_VALUE},
    // Fill the table in scrambled order so that later points move up.
    '{ROW_ITEM, OP_INSERT, 16'd65535, -16'sd300, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd32767, LVL_MIN, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd1, LVL_MAX, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd8192, 16'sd4096, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd24576, -16'sd4096, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd100, -16'sd1, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd30000, 16'sd12345, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd16384, 16'sd7, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd5000, -16'sd20000, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd20000, 16'sd20000, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    '{ROW_ITEM, OP_INSERT, 16'd0, 16'sd1, 16'sd0, 1'b1, 16'sd0, ST_INSERTED},
    // Sixteen points stored: the next insert is refused.
    '{ROW_ITEM, OP_INSERT, 16'd12000, 16'sd7, 16'sd0, 1'b1, 16'sd0, ST_FULL}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bei_req_if req_ch ();
  bei_rsp_if rsp_ch ();

  breakpoint_envelope_interpolator dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the breakpoint table and the two end levels.
  logic [POS_W-1:0] tbl_pos [MAX_POINTS];
  logic signed [LVL_W-1:0] tbl_lvl [MAX_POINTS];
  int tbl_count;
  logic signed [LVL_W-1:0] lvl_at_zero;
  logic signed [LVL_W-1:0] lvl_at_one;

  bei_rsp_t awaited_rsp [$];
  int fail_count;
  int eval_count;
  int insert_count;
  int refused_count;
  int checked_count;
  int level_settings;
  bit src_gaps;
  bit sink_stalls;
  int stall_left;

  always #2 clk = ~clk;

  // Index of the first stored point at or above x, or the point count.
  function automatic int first_not_below(logic [POS_W-1:0] x);
    int k;
    k = 0;
    while (k < tbl_count && tbl_pos[k] < x) k++;
    return k;
  endfunction

  // Linear interpolation between the neighbours of x, truncating toward zero.
  function automatic logic signed [LVL_W-1:0] envelope_at(logic [POS_W-1:0] x);
    int k;
    longint xq, lo_pos, hi_pos, lo_lvl, hi_lvl, span;
    if (x == '0) return lvl_at_zero;
    if (x >= POS_ONE) return lvl_at_one;
    xq = longint'(x);
    k = first_not_below(x);
    if (k >= tbl_count) begin
      hi_pos = 32768;
      hi_lvl = longint'(lvl_at_one);
    end else begin
      hi_pos = longint'(tbl_pos[k]);
      hi_lvl = longint'(tbl_lvl[k]);
    end
    if (k == 0) begin
      lo_pos = 0;
      lo_lvl = longint'(lvl_at_zero);
    end else begin
      lo_pos = longint'(tbl_pos[k-1]);
      lo_lvl = longint'(tbl_lvl[k-1]);
    end
    if (hi_pos <= lo_pos) return LVL_W'(lo_lvl);
    span = (hi_lvl - lo_lvl) * (xq - lo_pos);
    return LVL_W'(lo_lvl + span / (hi_pos - lo_pos));
  endfunction

  // Sorted insert; positions above one are clamped to one.
  function automatic logic [STATUS_W-1:0] add_point(logic [POS_W-1:0] x,
                                                    logic signed [LVL_W-1:0] lv);
    int k;
    int j;
    if (tbl_count >= MAX_POINTS) return ST_FULL;
    if (x > POS_ONE) x = POS_ONE;
    k = first_not_below(x);
    for (j = tbl_count; j > k; j--) begin
      tbl_pos[j] = tbl_pos[j-1];
      tbl_lvl[j] = tbl_lvl[j-1];
    end
    tbl_pos[k] = x;
    tbl_lvl[k] = lv;
    tbl_count++;
    return ST_INSERTED;
  endfunction

  function automatic bei_rsp_t envelope_response(bei_req_t r);
    bei_rsp_t res;
    if (r.opcode == OP_EVAL) begin
      res.value = envelope_at(r.position);
      res.status = ST_VALUE;
    end else begin
      res.value = '0;
      res.status = add_point(r.position, r.level);
    end
    return res;
  endfunction

  // Offer one request and record its expected result once it is taken.
  task automatic issue(input bei_req_t item, input bit known, input bei_rsp_t typed);
    bei_rsp_t want;
    req_ch.data <= item;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    want = envelope_response(item);
    if (known) want = typed;
    awaited_rsp.push_back(want);
    if (item.opcode == OP_EVAL) eval_count++;
    else insert_count++;
    if (want.status == ST_FULL) refused_count++;
  endtask

  // Random gap on the request side.
  task automatic maybe_pause();
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result plus the pipeline tail.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_levels(input logic signed [LVL_W-1:0] lo,
                            input logic signed [LVL_W-1:0] hi);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_START;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_END;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    lvl_at_zero = lo;
    lvl_at_one = hi;
    level_settings++;
  endtask

  // Random request: mostly evaluates, aimed at ends, stored points and between.
  function automatic bei_req_t random_request();
    bei_req_t r;
    int pick;
    int idx;
    r.level = LVL_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      r.opcode = OP_INSERT;
      r.position = POS_W'($urandom);
      return r;
    end
    r.opcode = OP_EVAL;
    pick = $urandom_range(0, 9);
    idx = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
    if (pick == 0) r.position = '0;
    else if (pick == 1) r.position = POS_W'($urandom_range(32768, 65535));
    else if (pick == 2 && tbl_count > 0) r.position = tbl_pos[idx];
    else if (pick == 3 && tbl_count > 0) begin
      r.position = ($urandom_range(0, 1) == 1) ? tbl_pos[idx] + 1'b1 : tbl_pos[idx] - 1'b1;
    end else r.position = POS_W'($urandom_range(1, 32767));
    return r;
  endfunction

  // Result side: while sink stalls are enabled, ready drops in bursts of random length.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= (stall_left == 1);
    end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= $urandom_range(1, 12) - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    bei_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("result with no request outstanding: value %0d status %0d",
               rsp_ch.data.value, rsp_ch.data.status);
        fail_count++;
      end else begin
        want = awaited_rsp.pop_front();
        checked_count++;
        if (rsp_ch.data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, rsp_ch.data.value);
          fail_count++;
        end
        if (rsp_ch.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.data.status);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin : stimulus
    bei_req_t item;
    bei_rsp_t typed;
    int p;
    int n;
    int waited;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_START;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    tbl_count = 0;
    lvl_at_zero = '0;
    lvl_at_one = '0;
    fail_count = 0;
    eval_count = 0;
    insert_count = 0;
    refused_count = 0;
    checked_count = 0;
    level_settings = 0;
    stall_left = 0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_LEVELS) begin
        set_levels(DIRECTED[i].level, DIRECTED[i].end_level);
      end else begin
        item.opcode = DIRECTED[i].opcode;
        item.position = DIRECTED[i].position;
        item.level = DIRECTED[i].level;
        typed.value = DIRECTED[i].value;
        typed.status = DIRECTED[i].status;
        issue(item, DIRECTED[i].known, typed);
        maybe_pause();
      end
    end

    // Each phase picks new end levels; the last one runs without idling.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_levels(LVL_MAX, LVL_MIN);
        1: set_levels('0, '0);
        3: set_levels(-16'sd1, 16'sd1);
        default: set_levels(LVL_W'($urandom), LVL_W'($urandom));
      endcase
      src_gaps = (p != 1) && (p != RANDOM_PHASES - 1);
      sink_stalls = (p != 2) && (p != RANDOM_PHASES - 1);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        issue(random_request(), 1'b0, '0);
        maybe_pause();
      end
    end

    // Drain with a bound, then watch for stray results.
    req_ch.valid <= 1'b0;
    waited = 0;
    while (awaited_rsp.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_rsp.size() != 0) begin
      $error("%0d expected results never arrived", awaited_rsp.size());
      fail_count += awaited_rsp.size();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d evaluates and %0d inserts (%0d refused on a full table)",
             eval_count, insert_count, refused_count);
    $display("across %0d end level settings; %0d results compared.",
             level_settings, checked_count);
    if (fail_count == 0) begin
      $display("breakpoint_envelope_interpolator_tb passed");
    end else begin
      $display("breakpoint_envelope_interpolator_tb failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #2_000_000;
    $display("breakpoint_envelope_interpolator_tb failed");
    $finish;
  end

endmodule
